// File: rtl/core/psd_pkg.sv
// Shared constants for the point-to-segment distance block.
package psd_pkg;

  // Default coordinate width and projection fraction bits
  localparam int COORD_BITS_DEF     = 16;
  localparam int PROJ_FRAC_BITS_DEF = 16;

  // Fixed output field widths
  localparam int DIST_W = 17;
  localparam int PROJ_W = 17;

endpackage

// File: rtl/core/psd_in_if.sv
// Request channel carrying a query point and a segment.
interface psd_in_if #(
  parameter int CW = psd_pkg::COORD_BITS_DEF
);
  logic          valid;
  logic          ready;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic signed [CW-1:0] start_x;
  logic signed [CW-1:0] start_y;
  logic signed [CW-1:0] end_x;
  logic signed [CW-1:0] end_y;

  modport source (output valid, point_x, point_y, start_x, start_y, end_x, end_y,
                  input ready);
  modport sink   (input valid, point_x, point_y, start_x, start_y, end_x, end_y,
                  output ready);
endinterface

// File: rtl/core/psd_out_if.sv
// Result channel carrying distance, projection and degenerate flag.
interface psd_out_if;
  logic                        valid;
  logic                        ready;
  logic [psd_pkg::DIST_W-1:0]  distance;
  logic [psd_pkg::PROJ_W-1:0]  projection;
  logic                        degenerate;

  modport source (output valid, distance, projection, degenerate, input ready);
  modport sink   (input valid, distance, projection, degenerate, output ready);
endinterface

// File: rtl/core/point_segment_distance_top.sv
// Top level: pipelined point-to-segment distance with cell chains.
//
// Fully pipelined: one request per cycle unless stalled, with 7 + PROJ_FRAC_BITS +
// (COORD_BITS + 4) register stages (7 + 16 + 20 = 43 at the defaults). The
// projection quotient comes from a chain of PROJ_FRAC_BITS restoring-division
// cells and the distance from a chain of COORD_BITS + 4 square-root cells,
// each retiring one step per cycle. The whole pipe stalls together only when
// the final result is held by a busy consumer.
module point_segment_distance_top #(
  parameter int COORD_BITS     = psd_pkg::COORD_BITS_DEF,
  parameter int PROJ_FRAC_BITS = psd_pkg::PROJ_FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  psd_in_if.sink    in_req,
  psd_out_if.source out_res
);

  localparam int CW   = COORD_BITS;
  localparam int F    = PROJ_FRAC_BITS;
  localparam int DW   = CW + 1;
  localparam int L2W  = 2 * CW + 1;
  localparam int DOTW = 2 * CW + 2;
  localparam int TW   = F + 1;
  localparam int PW   = DW + TW + 1;
  localparam int QW   = DW + 3;
  localparam int SW   = 2 * QW;
  localparam int RW   = QW;
  localparam int DSIDE = 4 * DW + 2;
  localparam int SSIDE = TW + 1;

  logic en;
  logic v_last;

  // global advance: move when the output slot is free or being taken
  assign en           = !v_last || out_res.ready;
  assign in_req.ready = en;

  // stage 1: differences
  logic v1;
  logic signed [DW-1:0] dx1, dy1, rx1, ry1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_req.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dx1 <= DW'(in_req.end_x)   - DW'(in_req.start_x);
      dy1 <= DW'(in_req.end_y)   - DW'(in_req.start_y);
      rx1 <= DW'(in_req.point_x) - DW'(in_req.start_x);
      ry1 <= DW'(in_req.point_y) - DW'(in_req.start_y);
    end
  end

  // stage 2: products
  logic v2;
  logic signed [DW-1:0]   dx2, dy2, rx2, ry2;
  logic signed [2*DW-1:0] mxx, myy, mrx, mry;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mxx <= dx1 * dx1;
      myy <= dy1 * dy1;
      mrx <= rx1 * dx1;
      mry <= ry1 * dy1;
      dx2 <= dx1;
      dy2 <= dy1;
      rx2 <= rx1;
      ry2 <= ry1;
    end
  end

  // stage 3: length squared, dot product, clamp decision
  logic [2*DW:0]         len2_sum;
  logic signed [2*DW:0]  dot_sum;
  logic [L2W-1:0]        len2_c;
  logic signed [DOTW-1:0] dot_c;
  logic                  low_c, high_c;
  assign len2_sum = {1'b0, mxx} + {1'b0, myy};
  assign dot_sum  = {mrx[2*DW-1], mrx} + {mry[2*DW-1], mry};
  assign len2_c   = L2W'(len2_sum);
  assign dot_c    = DOTW'(dot_sum);
  assign low_c    = dot_c <= 0;
  assign high_c   = !low_c && (dot_c >= $signed({1'b0, len2_c}));

  logic v3;
  logic [L2W-1:0]   len2_3, rem_3;
  logic [DSIDE-1:0] side_3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      len2_3 <= len2_c;
      rem_3  <= (low_c || high_c) ? '0 : L2W'(dot_c);
      side_3 <= {rx2, ry2, dx2, dy2, low_c, high_c};
    end
  end

  // division chain
  logic             dv   [F+1];
  logic [L2W-1:0]   drem [F+1];
  logic [F-1:0]     dq   [F+1];
  logic [L2W-1:0]   dlen [F+1];
  logic [DSIDE-1:0] dside[F+1];
  assign dv[0]    = v3;
  assign drem[0]  = rem_3;
  assign dq[0]    = '0;
  assign dlen[0]  = len2_3;
  assign dside[0] = side_3;

  for (genvar i = 0; i < F; i++) begin : g_div
    psd_div_cell #(.L2W(L2W), .TBW(F), .SIDE(DSIDE)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .v_in(dv[i]), .rem_in(drem[i]), .q_in(dq[i]), .len2_in(dlen[i]),
      .side_in(dside[i]),
      .v_out(dv[i+1]), .rem_out(drem[i+1]), .q_out(dq[i+1]),
      .len2_out(dlen[i+1]), .side_out(dside[i+1])
    );
  end

  // unpack division side data, form clamped projection
  logic signed [DW-1:0] rxd, ryd, dxd, dyd;
  logic                 lowd, highd;
  logic [TW-1:0]        tfin;
  assign {rxd, ryd, dxd, dyd, lowd, highd} = dside[F];
  always_comb begin
    if (lowd) tfin = '0;
    else if (highd) tfin = {1'b1, {F{1'b0}}};
    else tfin = {1'b0, dq[F]};
  end

  // stage M: d * t
  logic v4;
  logic signed [PW-1:0] px4, py4;
  logic signed [DW-1:0] rx4, ry4;
  logic [TW-1:0]        t4;
  logic                 dg4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= dv[F];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      px4 <= dxd * $signed({1'b0, tfin});
      py4 <= dyd * $signed({1'b0, tfin});
      rx4 <= rxd;
      ry4 <= ryd;
      t4  <= tfin;
      dg4 <= (dlen[F] == '0);
    end
  end

  // stage Q: offset from closest point (arithmetic shift floors)
  logic signed [PW-1:0] pxs, pys;
  assign pxs = px4 >>> F;
  assign pys = py4 >>> F;

  logic v5;
  logic signed [QW-1:0] qx5, qy5;
  logic [TW-1:0]        t5;
  logic                 dg5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      qx5 <= QW'(rx4) - QW'(pxs);
      qy5 <= QW'(ry4) - QW'(pys);
      t5  <= t4;
      dg5 <= dg4;
    end
  end

  // stage S: squares
  logic v6;
  logic signed [2*QW-1:0] sx6, sy6;
  logic [TW-1:0]          t6;
  logic                   dg6;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sx6 <= qx5 * qx5;
      sy6 <= qy5 * qy5;
      t6  <= t5;
      dg6 <= dg5;
    end
  end

  // stage N: squared distance
  logic v7;
  logic [SW-1:0]    n7;
  logic [SSIDE-1:0] side_7;
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      n7     <= SW'(sx6) + SW'(sy6);
      side_7 <= {t6, dg6};
    end
  end

  // square-root chain
  logic             sv   [RW+1];
  logic [SW-1:0]    sn   [RW+1];
  logic [RW+1:0]    srem [RW+1];
  logic [RW-1:0]    sroot[RW+1];
  logic [SSIDE-1:0] sside[RW+1];
  assign sv[0]    = v7;
  assign sn[0]    = n7;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign sside[0] = side_7;

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    psd_sqrt_cell #(.SW(SW), .RW(RW), .SIDE(SSIDE)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .v_in(sv[j]), .n_in(sn[j]), .rem_in(srem[j]), .root_in(sroot[j]),
      .side_in(sside[j]),
      .v_out(sv[j+1]), .n_out(sn[j+1]), .rem_out(srem[j+1]),
      .root_out(sroot[j+1]), .side_out(sside[j+1])
    );
  end

  // last cell registers serve as the output slot
  logic [TW-1:0] t_out;
  logic          dg_out;
  assign {t_out, dg_out}    = sside[RW];
  assign v_last             = sv[RW];
  assign out_res.valid      = v_last;
  assign out_res.distance   = psd_pkg::DIST_W'(sroot[RW]);
  assign out_res.projection = psd_pkg::PROJ_W'(t_out);
  assign out_res.degenerate = dg_out;

endmodule

// File: rtl/core/psd_div_cell.sv
// One restoring division step for the projection quotient.
module psd_div_cell #(
  parameter int L2W  = 33,
  parameter int TBW  = 16,
  parameter int SIDE = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            v_in,
  input  logic [L2W-1:0]  rem_in,
  input  logic [TBW-1:0]  q_in,
  input  logic [L2W-1:0]  len2_in,
  input  logic [SIDE-1:0] side_in,
  output logic            v_out,
  output logic [L2W-1:0]  rem_out,
  output logic [TBW-1:0]  q_out,
  output logic [L2W-1:0]  len2_out,
  output logic [SIDE-1:0] side_out
);

  logic [L2W:0] shifted;
  logic         take;

  // shift remainder, compare against the squared length
  assign shifted = {rem_in, 1'b0};
  assign take    = shifted >= {1'b0, len2_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= take ? L2W'(shifted - {1'b0, len2_in}) : L2W'(shifted);
      q_out    <= {q_in[TBW-2:0], take};
      len2_out <= len2_in;
      side_out <= side_in;
    end
  end

endmodule

// File: rtl/core/psd_sqrt_cell.sv
// One digit-by-digit integer square root step (two radicand bits per cell).
module psd_sqrt_cell #(
  parameter int SW   = 40,
  parameter int RW   = 20,
  parameter int SIDE = 18
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            v_in,
  input  logic [SW-1:0]   n_in,
  input  logic [RW+1:0]   rem_in,
  input  logic [RW-1:0]   root_in,
  input  logic [SIDE-1:0] side_in,
  output logic            v_out,
  output logic [SW-1:0]   n_out,
  output logic [RW+1:0]   rem_out,
  output logic [RW-1:0]   root_out,
  output logic [SIDE-1:0] side_out
);

  logic [RW+3:0] rem_s;
  logic [RW+3:0] trial;
  logic          take;

  // bring down the next two radicand bits and try root*4+1
  assign rem_s = {rem_in, n_in[SW-1:SW-2]};
  assign trial = {2'b00, root_in, 2'b01};
  assign take  = rem_s >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_out    <= {n_in[SW-3:0], 2'b00};
      rem_out  <= take ? (RW+2)'(rem_s - trial) : (RW+2)'(rem_s);
      root_out <= {root_in[RW-2:0], take};
      side_out <= side_in;
    end
  end

endmodule

// File: tb/sv/psd_checker.sv
// Checker for the point-to-segment distance block: predicts and compares results.
`timescale 1ns / 1ps
module psd_checker (
  input  logic      clk,
  input  logic      rst,
  psd_in_if         in_req,
  psd_out_if        out_res,
  output int        fail_count,
  output int        pending
);
  typedef struct packed {
    logic [psd_pkg::DIST_W-1:0] distance;
    logic [psd_pkg::PROJ_W-1:0] projection;
    logic                       degenerate;
  } seg_dist_t;

  seg_dist_t expected_q[$];

  // Integer square root, floor
  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Distance, clamped projection and degenerate flag for one request
  function automatic seg_dist_t predict_distance(
    logic signed [15:0] px, logic signed [15:0] py,
    logic signed [15:0] sx, logic signed [15:0] sy,
    logic signed [15:0] ex, logic signed [15:0] ey);
    longint dx, dy, rx, ry, dot, qx, qy;
    longint unsigned len2, rem, t;
    seg_dist_t r;
    dx = longint'(ex) - longint'(sx);
    dy = longint'(ey) - longint'(sy);
    rx = longint'(px) - longint'(sx);
    ry = longint'(py) - longint'(sy);
    len2 = dx * dx + dy * dy;
    t = 0;
    if (len2 == 0) begin
      qx = rx;
      qy = ry;
    end else begin
      dot = rx * dx + ry * dy;
      if (dot <= 0) begin
        t = 0;
      end else if ($unsigned(dot) >= len2) begin
        t = 64'd1 << 16;
      end else begin
        rem = dot;
        for (int i = 0; i < 16; i++) begin
          rem = rem << 1;
          t = t << 1;
          if (rem >= len2) begin
            rem = rem - len2;
            t = t | 1;
          end
        end
      end
      // arithmetic shift floors toward minus infinity
      qx = rx - ((dx * longint'(t)) >>> 16);
      qy = ry - ((dy * longint'(t)) >>> 16);
    end
    r.distance   = psd_pkg::DIST_W'(isqrt(qx * qx + qy * qy));
    r.projection = psd_pkg::PROJ_W'(t);
    r.degenerate = (len2 == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    seg_dist_t want;
    if (rst) begin
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (in_req.valid && in_req.ready)
        expected_q.push_back(predict_distance(in_req.point_x, in_req.point_y,
          in_req.start_x, in_req.start_y, in_req.end_x, in_req.end_y));
      if (out_res.valid && out_res.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result dist=%0d proj=%0d degen=%0d", $time,
                   out_res.distance, out_res.projection, out_res.degenerate);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.distance !== out_res.distance ||
              want.projection !== out_res.projection ||
              want.degenerate !== out_res.degenerate) begin
            $display("%0t: expected dist=%0d proj=%0d degen=%0d, got %0d %0d %0d",
                     $time, want.distance, want.projection, want.degenerate,
                     out_res.distance, out_res.projection, out_res.degenerate);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_q.size();
    end
  end
endmodule

// File: tb/sv/tb_point_segment_distance_top.sv
// Testbench top: drives requests with idling phases and reports the verdict.
`timescale 1ns / 1ps
module tb_point_segment_distance_top;
  logic clk = 0;
  logic rst = 1;
  int   fail_count;
  int   pending;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   long_hold = 0;

  psd_in_if  in_req ();
  psd_out_if out_res ();

  point_segment_distance_top dut (.clk(clk), .rst(rst), .in_req(in_req), .out_res(out_res));
  psd_checker chk (.clk(clk), .rst(rst), .in_req(in_req), .out_res(out_res),
                   .fail_count(fail_count), .pending(pending));

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Result side: random stalls, or a long hold-off when asked
  always @(negedge clk) begin
    if (rst) out_res.ready <= 0;
    else if (long_hold) out_res.ready <= 0;
    else out_res.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    out_res.ready = 0;
    #200000;
    $display("tb_point_segment_distance_top NOT OK");
    $finish;
  end

  // Coordinate picker biased toward extremes
  function automatic logic [15:0] pick_coord();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3, 4: return 16'($signed($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_request(logic [15:0] px, logic [15:0] py, logic [15:0] sx,
                              logic [15:0] sy, logic [15:0] ex, logic [15:0] ey);
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 0;
      @(negedge clk);
    end
    in_req.valid   <= 1;
    in_req.point_x <= px;
    in_req.point_y <= py;
    in_req.start_x <= sx;
    in_req.start_y <= sy;
    in_req.end_x   <= ex;
    in_req.end_y   <= ey;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [15:0] sx, sy;
    sx = pick_coord();
    sy = pick_coord();
    // occasional degenerate segment
    if ($urandom_range(9) == 0)
      send_request(pick_coord(), pick_coord(), sx, sy, sx, sy);
    else
      send_request(pick_coord(), pick_coord(), sx, sy, pick_coord(), pick_coord());
  endtask

  initial begin
    in_req.valid = 0;
    {in_req.point_x, in_req.point_y, in_req.start_x} = '0;
    {in_req.start_y, in_req.end_x, in_req.end_y} = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: extremes, degenerate, clamp on both ends, interior projection
    send_request(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_request(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_request(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_request(16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_request(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_request(16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'h0001, 16'h0000);
    send_request(16'h0100, 16'h0010, 16'h0000, 16'h0000, 16'h0010, 16'h0000);
    send_request(16'hff00, 16'h0010, 16'h0000, 16'h0000, 16'h0010, 16'h0000);
    send_request(16'h0005, 16'h0030, 16'h0000, 16'h0000, 16'h0010, 16'h0000);
    send_request(16'h0007, 16'hfff3, 16'h0003, 16'h0000, 16'hfffd, 16'h0001);
    send_request(16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'h1234, 16'hedcb);
    send_request(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000);

    // Idling phases: none, sender, receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 67 : (ph == 3) ? 12 : 0;
      recv_stall_pct = (ph == 2) ? 67 : (ph == 3) ? 12 : 0;
      repeat (280) send_random();
    end

    // Long receiver hold-off while requests keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        long_hold = 1;
        repeat (200) @(posedge clk);
        long_hold = 0;
      end
      repeat (100) send_random();
    join
    in_req.valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0)
      $display("tb_point_segment_distance_top OK");
    else
      $display("tb_point_segment_distance_top NOT OK");
    $finish;
  end
endmodule
